/* src/lpsrc_pkg.sv */
`timescale 1ns / 1ps

package lpsrc_pkg;

    localparam int LEN_BITS = 16;

    localparam logic [15:0] LEN_MASK = (LEN_BITS >= 16) ? 16'hFFFF
                                     : 16'((64'd1 << LEN_BITS) - 64'd1);

    localparam logic [15:0] MAX_LEN_RST = 16'd8192;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic MODE_PACK   = 1'b0;
    localparam logic MODE_UNPACK = 1'b1;

    localparam logic FUNC_BEGIN = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_P_DATA,
        PH_U_LEN_H,
        PH_U_LEN_L,
        PH_U_DATA,
        PH_U_SUM_H,
        PH_U_SUM_L
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TOOLONG,
        ST_BADSUM,
        ST_STRAY
    } t_status;

    // DATA: one byte, optionally followed by the check word
    // HDR:  two length bytes, optionally followed by the check word
    // STAT: a single verdict
    typedef enum logic [1:0] {
        K_DATA,
        K_HDR,
        K_STAT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [15:0] sum;
        logic        with_sum;
        t_status     status;
    } t_cmd;

    function automatic logic [15:0] len_mask(input logic [15:0] v);
        return v & LEN_MASK;
    endfunction

endpackage

/* src/lpsrc_front.sv */
`timescale 1ns / 1ps

module lpsrc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_func,
    input  logic [7:0]           i_in_byte,
    input  logic [15:0]          i_record_len,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_cmd_push,
    output lpsrc_pkg::t_cmd      o_cmd
);

    lpsrc_pkg::t_phase r_phase, n_phase;
    logic              r_mode, n_mode;
    logic [15:0]       r_max_len, n_max_len;
    logic [15:0]       r_bytes_left, n_bytes_left;
    logic [15:0]       r_sum, n_sum;
    logic [7:0]        r_held, n_held;

    logic [15:0] w_begin_len;
    logic [15:0] w_parsed_len;
    logic [15:0] w_sum_b;
    logic [15:0] w_left_dec;

    assign w_begin_len  = lpsrc_pkg::len_mask(i_record_len);
    assign w_parsed_len = lpsrc_pkg::len_mask({r_held, i_in_byte});
    assign w_sum_b      = r_sum + {8'd0, i_in_byte};
    assign w_left_dec   = r_bytes_left - 16'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_cfg_we && i_cfg_idx == lpsrc_pkg::CFG_MODE) begin
            n_phase = lpsrc_pkg::PH_IDLE;
        end else if (i_accept) begin
            if (i_func == lpsrc_pkg::FUNC_BEGIN) begin
                if (r_mode == lpsrc_pkg::MODE_PACK) begin
                    n_phase = (w_begin_len == 16'd0) ? lpsrc_pkg::PH_IDLE
                                                     : lpsrc_pkg::PH_P_DATA;
                end else begin
                    n_phase = lpsrc_pkg::PH_U_LEN_H;
                end
            end else begin
                unique case (r_phase)
                    lpsrc_pkg::PH_P_DATA: begin
                        if (w_left_dec == 16'd0) n_phase = lpsrc_pkg::PH_IDLE;
                    end
                    lpsrc_pkg::PH_U_LEN_H: n_phase = lpsrc_pkg::PH_U_LEN_L;
                    lpsrc_pkg::PH_U_LEN_L: begin
                        if (w_parsed_len > r_max_len) begin
                            n_phase = lpsrc_pkg::PH_IDLE;
                        end else if (w_parsed_len == 16'd0) begin
                            n_phase = lpsrc_pkg::PH_U_SUM_H;
                        end else begin
                            n_phase = lpsrc_pkg::PH_U_DATA;
                        end
                    end
                    lpsrc_pkg::PH_U_DATA: begin
                        if (w_left_dec == 16'd0) n_phase = lpsrc_pkg::PH_U_SUM_H;
                    end
                    lpsrc_pkg::PH_U_SUM_H: n_phase = lpsrc_pkg::PH_U_SUM_L;
                    default:               n_phase = lpsrc_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // datapath and command
    always_comb begin
        n_mode       = r_mode;
        n_max_len    = r_max_len;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_held       = r_held;
        o_cmd_push   = 1'b0;
        o_cmd.kind     = lpsrc_pkg::K_DATA;
        o_cmd.b0       = i_in_byte;
        o_cmd.b1       = 8'd0;
        o_cmd.sum      = w_sum_b;
        o_cmd.with_sum = 1'b0;
        o_cmd.status   = lpsrc_pkg::ST_OK;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lpsrc_pkg::CFG_MODE:    n_mode    = i_cfg_data[0];
                lpsrc_pkg::CFG_MAX_LEN: n_max_len = i_cfg_data;
            endcase
        end

        if (i_accept) begin
            if (i_func == lpsrc_pkg::FUNC_BEGIN) begin
                if (r_mode == lpsrc_pkg::MODE_PACK) begin
                    n_sum          = {8'd0, w_begin_len[15:8]} + {8'd0, w_begin_len[7:0]};
                    n_bytes_left   = w_begin_len;
                    o_cmd_push     = 1'b1;
                    o_cmd.kind     = lpsrc_pkg::K_HDR;
                    o_cmd.b0       = w_begin_len[15:8];
                    o_cmd.b1       = w_begin_len[7:0];
                    o_cmd.sum      = n_sum;
                    o_cmd.with_sum = (w_begin_len == 16'd0);
                end else begin
                    n_sum        = 16'd0;
                    n_bytes_left = 16'd0;
                end
            end else begin
                unique case (r_phase)
                    lpsrc_pkg::PH_P_DATA: begin
                        n_sum          = w_sum_b;
                        n_bytes_left   = w_left_dec;
                        o_cmd_push     = 1'b1;
                        o_cmd.with_sum = (w_left_dec == 16'd0);
                    end
                    lpsrc_pkg::PH_U_LEN_H: begin
                        n_held = i_in_byte;
                        n_sum  = w_sum_b;
                    end
                    lpsrc_pkg::PH_U_LEN_L: begin
                        n_sum = w_sum_b;
                        if (w_parsed_len > r_max_len) begin
                            o_cmd_push   = 1'b1;
                            o_cmd.kind   = lpsrc_pkg::K_STAT;
                            o_cmd.status = lpsrc_pkg::ST_TOOLONG;
                        end else begin
                            n_bytes_left = w_parsed_len;
                        end
                    end
                    lpsrc_pkg::PH_U_DATA: begin
                        n_sum        = w_sum_b;
                        n_bytes_left = w_left_dec;
                        o_cmd_push   = 1'b1;
                    end
                    lpsrc_pkg::PH_U_SUM_H: begin
                        n_held = i_in_byte;
                    end
                    lpsrc_pkg::PH_U_SUM_L: begin
                        o_cmd_push   = 1'b1;
                        o_cmd.kind   = lpsrc_pkg::K_STAT;
                        o_cmd.status = ({r_held, i_in_byte} == r_sum) ? lpsrc_pkg::ST_OK
                                                                       : lpsrc_pkg::ST_BADSUM;
                    end
                    default: begin
                        o_cmd_push   = 1'b1;
                        o_cmd.kind   = lpsrc_pkg::K_STAT;
                        o_cmd.status = lpsrc_pkg::ST_STRAY;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lpsrc_pkg::PH_IDLE;
            r_mode       <= lpsrc_pkg::MODE_PACK;
            r_max_len    <= lpsrc_pkg::MAX_LEN_RST;
            r_bytes_left <= 16'd0;
            r_sum        <= 16'd0;
            r_held       <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_mode       <= n_mode;
            r_max_len    <= n_max_len;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_held       <= n_held;
        end
    end

endmodule

/* src/lpsrc_cmd_fifo.sv */
`timescale 1ns / 1ps

module lpsrc_cmd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lpsrc_pkg::t_cmd  i_cmd,
    input  logic             i_pop,
    output lpsrc_pkg::t_cmd  o_head,
    output logic             o_empty,
    output logic             o_full
);

    lpsrc_pkg::t_cmd r_mem [lpsrc_pkg::CMD_DEPTH];

    logic [lpsrc_pkg::CMD_PTR_W-1:0] r_wptr, n_wptr;
    logic [lpsrc_pkg::CMD_PTR_W-1:0] r_rptr, n_rptr;
    logic [lpsrc_pkg::CMD_CNT_W-1:0] r_count, n_count;

    logic w_wr;
    logic w_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == lpsrc_pkg::CMD_CNT_W'(lpsrc_pkg::CMD_DEPTH));
    assign o_head  = r_mem[r_rptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_wr) begin
            if (r_wptr == lpsrc_pkg::CMD_PTR_W'(lpsrc_pkg::CMD_DEPTH - 1)) begin
                n_wptr = '0;
            end else begin
                n_wptr = r_wptr + lpsrc_pkg::CMD_PTR_W'(1);
            end
        end
        if (w_rd) begin
            if (r_rptr == lpsrc_pkg::CMD_PTR_W'(lpsrc_pkg::CMD_DEPTH - 1)) begin
                n_rptr = '0;
            end else begin
                n_rptr = r_rptr + lpsrc_pkg::CMD_PTR_W'(1);
            end
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + lpsrc_pkg::CMD_CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_count = r_count - lpsrc_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* src/lpsrc_back.sv */
`timescale 1ns / 1ps

module lpsrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpsrc_pkg::t_cmd  i_head,
    input  logic             i_empty,
    input  logic             i_pop,
    output logic             o_head_done,
    output logic [7:0]       o_out_byte,
    output logic             o_is_status,
    output logic [1:0]       o_status,
    output logic             o_last
);

    logic [1:0] r_idx, n_idx;
    logic [1:0] w_slot;
    logic [1:0] w_last_idx;
    logic       w_take;
    logic       w_end;

    // slot: 0 first byte, 1 second length byte, 2 sum high, 3 sum low
    always_comb begin
        w_slot = r_idx;
        if (i_head.kind == lpsrc_pkg::K_DATA && r_idx != 2'd0) begin
            w_slot = r_idx + 2'd1;
        end
    end

    always_comb begin
        unique case (i_head.kind)
            lpsrc_pkg::K_DATA: w_last_idx = i_head.with_sum ? 2'd2 : 2'd0;
            lpsrc_pkg::K_HDR:  w_last_idx = i_head.with_sum ? 2'd3 : 2'd1;
            default:           w_last_idx = 2'd0;
        endcase
    end

    always_comb begin
        o_is_status = 1'b0;
        o_status    = lpsrc_pkg::ST_OK;
        unique case (w_slot)
            2'd0: o_out_byte = i_head.b0;
            2'd1: o_out_byte = i_head.b1;
            2'd2: o_out_byte = i_head.sum[15:8];
            2'd3: o_out_byte = i_head.sum[7:0];
        endcase
        if (i_head.kind == lpsrc_pkg::K_STAT) begin
            o_out_byte  = 8'd0;
            o_is_status = 1'b1;
            o_status    = i_head.status;
        end
    end

    // end of the head command; last only closes a record or a verdict
    assign w_end       = (r_idx == w_last_idx);
    assign o_last      = w_end && (i_head.with_sum || i_head.kind == lpsrc_pkg::K_STAT);
    assign w_take      = i_pop && !i_empty;
    assign o_head_done = w_take && w_end;

    always_comb begin
        n_idx = r_idx;
        if (w_take) begin
            n_idx = w_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

/* src/length_prefixed_sum16_record_codec.sv */
`timescale 1ns / 1ps

// Channel   Handshake            Ports
// input     i_push / o_full      i_func, i_in_byte, i_record_len
// result    o_empty / i_pop      o_out_byte, o_is_status, o_status, o_last
// config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// One input item per cycle while o_full is low; the front decodes it and may
// queue one command in a four-entry command queue. The back sends one result
// per cycle from the head command while i_pop is high and the queue is not
// empty; a data byte gives one result, a header or closing record up to four.
// o_full rises only on a full queue. Reset is synchronous, no clearing pass.

module length_prefixed_sum16_record_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_func,
    input  logic [7:0]  i_in_byte,
    input  logic [15:0] i_record_len,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    lpsrc_pkg::t_cmd w_cmd;
    lpsrc_pkg::t_cmd w_head;
    logic            w_cmd_push;
    logic            w_head_done;
    logic            w_accept;

    assign w_accept = i_push && !o_full;

    lpsrc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_func       (i_func),
        .i_in_byte    (i_in_byte),
        .i_record_len (i_record_len),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_cmd_push   (w_cmd_push),
        .o_cmd        (w_cmd)
    );

    lpsrc_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_head_done),
        .o_head  (w_head),
        .o_empty (o_empty),
        .o_full  (o_full)
    );

    lpsrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (o_empty),
        .i_pop       (i_pop),
        .o_head_done (w_head_done),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
